@@ rtl/sba_pkg.sv @@
package sba_pkg;

    localparam int MAX_BLOCKS = 16;
    localparam int IDX_W      = $clog2(MAX_BLOCKS);
    localparam int CNT_W      = $clog2(MAX_BLOCKS + 1);

    localparam logic [15:0] SMALL_REST = 16'd256;

    localparam logic [1:0] CFG_FIT_MODE  = 2'd0;
    localparam logic [1:0] CFG_START_SEG = 2'd1;
    localparam logic [1:0] CFG_END_SEG   = 2'd2;

    localparam logic       RST_FIT_MODE  = 1'b0;
    localparam logic [15:0] RST_START_SEG = 16'd256;
    localparam logic [15:0] RST_END_SEG   = 16'd40960;

    localparam logic REQ_ALLOC = 1'b0;
    localparam logic REQ_FREE  = 1'b1;

    localparam logic FIT_FIRST = 1'b0;
    localparam logic FIT_LAST  = 1'b1;

    typedef struct packed {
        logic        used;
        logic [15:0] size;
        logic [15:0] start;
    } entry_t;

    typedef struct packed {
        logic init;
        logic load;
        logic scan;
        logic decide;
        logic shift;
        logic wr_hi;
        logic finish;
    } cmd_t;

    typedef struct packed {
        logic             cfg_wr;
        logic             hit;
        logic             miss;
        logic             split;
        logic             shift_done;
        logic             out_free;
        logic [CNT_W-1:0] count;
    } status_t;

endpackage

@@ rtl/sba_ctrl.sv @@
module sba_ctrl
    import sba_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    s_tvalid,
    output logic    s_tready,
    input  status_t st,
    output cmd_t    cmd
);

    localparam logic [2:0] ST_INIT   = 3'd0;
    localparam logic [2:0] ST_IDLE   = 3'd1;
    localparam logic [2:0] ST_SCAN   = 3'd2;
    localparam logic [2:0] ST_DECIDE = 3'd3;
    localparam logic [2:0] ST_SHIFT  = 3'd4;
    localparam logic [2:0] ST_WR_HI  = 3'd5;
    localparam logic [2:0] ST_FINISH = 3'd6;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    assign s_tready = (state_reg == ST_IDLE);

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_INIT: begin
                cmd.init   = 1'b1;
                state_next = ST_IDLE;
            end
            ST_IDLE: begin
                if (s_tvalid) begin
                    cmd.load   = 1'b1;
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN: begin
                cmd.scan = 1'b1;
                if (st.hit || st.miss) begin
                    state_next = ST_DECIDE;
                end
            end
            ST_DECIDE: begin
                cmd.decide = 1'b1;
                state_next = st.split ? ST_SHIFT : ST_FINISH;
            end
            ST_SHIFT: begin
                cmd.shift = 1'b1;
                if (st.shift_done) begin
                    state_next = ST_WR_HI;
                end
            end
            ST_WR_HI: begin
                cmd.wr_hi  = 1'b1;
                state_next = ST_FINISH;
            end
            ST_FINISH: begin
                if (st.out_free) begin
                    cmd.finish = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_INIT;
            end
        endcase
        if (st.cfg_wr) begin
            state_next = ST_INIT;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_INIT;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

@@ rtl/sba_datapath.sv @@
module sba_datapath
    import sba_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  cmd_t        cmd,
    output status_t     st,
    input  logic [39:0] s_tdata,
    input  logic        s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,
    input  logic        cfg_valid,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    entry_t mem [MAX_BLOCKS];

    logic             fit_mode_reg;
    logic [15:0]      start_seg_reg;
    logic [15:0]      end_seg_reg;
    logic [CNT_W-1:0] count_reg;

    logic             req_reg;
    logic [16:0]      need_reg;
    logic [15:0]      fseg_reg;

    logic [CNT_W-1:0] n_reg;
    logic             rd_vld_reg;
    logic [IDX_W-1:0] rd_idx_reg;
    entry_t           rd_data_reg;

    logic             found_reg;
    entry_t           hit_reg;
    logic [IDX_W-1:0] hit_idx_reg;
    entry_t           hi_reg;

    logic [IDX_W-1:0] sh_rd_reg;
    logic [CNT_W-1:0] sh_left_reg;
    logic             sh_wvld_reg;
    logic [IDX_W-1:0] sh_widx_reg;

    logic             ok_reg;
    logic [15:0]      seg_reg;
    logic             m_valid_reg;
    logic             m_ok_reg;
    logic [15:0]      m_seg_reg;

    logic             cfg_wr;
    logic [16:0]      need_in;
    logic             backward;
    logic             issue;
    logic [CNT_W-1:0] back_n;
    logic [IDX_W-1:0] scan_addr;
    logic [IDX_W-1:0] rd_addr;
    logic             match;
    logic [15:0]      rest;
    logic             rest_small;
    logic             full;
    logic             split;
    entry_t           lo_ent;
    entry_t           hi_ent;
    logic [15:0]      split_seg;
    logic [CNT_W-1:0] moves;
    logic             we;
    logic [IDX_W-1:0] waddr;
    entry_t           wdata;

    assign cfg_wr = cfg_valid && (cfg_index == CFG_FIT_MODE || cfg_index == CFG_START_SEG ||
                                  cfg_index == CFG_END_SEG);

    assign need_in = {1'b0, s_tdata[19:4]} + 17'(|s_tdata[3:0]) + 17'(s_tdata[20]);

    assign backward  = (fit_mode_reg == FIT_LAST) && (req_reg == REQ_ALLOC);
    assign issue     = cmd.scan && (n_reg < count_reg);
    assign back_n    = count_reg - CNT_W'(1) - n_reg;
    assign scan_addr = backward ? back_n[IDX_W-1:0] : n_reg[IDX_W-1:0];
    assign rd_addr   = cmd.shift ? sh_rd_reg : scan_addr;

    always_comb begin
        if (req_reg == REQ_ALLOC) begin
            match = !rd_data_reg.used && ({1'b0, rd_data_reg.size} >= need_reg);
        end else begin
            match = rd_data_reg.used && (rd_data_reg.start == fseg_reg);
        end
    end

    assign rest       = hit_reg.size - need_reg[15:0];
    assign rest_small = (rest <= SMALL_REST);
    assign full       = (count_reg >= CNT_W'(MAX_BLOCKS));
    assign split      = found_reg && (req_reg == REQ_ALLOC) && !rest_small && !full;
    assign moves      = count_reg - CNT_W'(1) - CNT_W'(hit_idx_reg);

    always_comb begin
        if (fit_mode_reg == FIT_FIRST) begin
            split_seg = hit_reg.start;
            lo_ent    = '{used: 1'b1, size: need_reg[15:0], start: hit_reg.start};
            hi_ent    = '{used: 1'b0, size: rest, start: hit_reg.start + need_reg[15:0]};
        end else begin
            split_seg = hit_reg.start + rest;
            lo_ent    = '{used: 1'b0, size: rest, start: hit_reg.start};
            hi_ent    = '{used: 1'b1, size: need_reg[15:0], start: hit_reg.start + rest};
        end
    end

    always_comb begin
        we    = 1'b0;
        waddr = hit_idx_reg;
        wdata = hit_reg;
        if (cmd.init) begin
            we          = 1'b1;
            waddr       = '0;
            wdata.used  = 1'b0;
            wdata.start = start_seg_reg;
            wdata.size  = (end_seg_reg >= start_seg_reg) ? end_seg_reg - start_seg_reg : 16'd0;
        end else if (cmd.decide && found_reg) begin
            if (req_reg == REQ_FREE) begin
                we         = 1'b1;
                wdata.used = 1'b0;
            end else if (rest_small) begin
                we         = 1'b1;
                wdata.used = 1'b1;
            end else if (!full) begin
                we    = 1'b1;
                wdata = lo_ent;
            end
        end else if (cmd.shift && sh_wvld_reg) begin
            we    = 1'b1;
            waddr = sh_widx_reg;
            wdata = rd_data_reg;
        end else if (cmd.wr_hi) begin
            we    = 1'b1;
            waddr = hit_idx_reg + IDX_W'(1);
            wdata = hi_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rd_data_reg <= mem[rd_addr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fit_mode_reg  <= RST_FIT_MODE;
            start_seg_reg <= RST_START_SEG;
            end_seg_reg   <= RST_END_SEG;
            count_reg     <= CNT_W'(1);
            rd_vld_reg    <= 1'b0;
            found_reg     <= 1'b0;
            sh_wvld_reg   <= 1'b0;
            sh_left_reg   <= '0;
            n_reg         <= '0;
            m_valid_reg   <= 1'b0;
        end else begin
            if (cfg_valid) begin
                unique case (cfg_index)
                    CFG_FIT_MODE:  fit_mode_reg  <= cfg_data[0];
                    CFG_START_SEG: start_seg_reg <= cfg_data;
                    CFG_END_SEG:   end_seg_reg   <= cfg_data;
                    default: ;
                endcase
            end
            if (cmd.init) begin
                count_reg <= CNT_W'(1);
            end else if (cmd.wr_hi) begin
                count_reg <= count_reg + CNT_W'(1);
            end
            if (cmd.load) begin
                n_reg      <= '0;
                rd_vld_reg <= 1'b0;
                found_reg  <= 1'b0;
            end else begin
                rd_vld_reg <= issue;
                if (issue) begin
                    n_reg <= n_reg + CNT_W'(1);
                end
                if (cmd.scan && rd_vld_reg && match) begin
                    found_reg <= 1'b1;
                end
            end
            if (cmd.decide) begin
                sh_left_reg <= moves;
                sh_wvld_reg <= 1'b0;
            end else if (cmd.shift) begin
                sh_wvld_reg <= (sh_left_reg != '0);
                if (sh_left_reg != '0) begin
                    sh_left_reg <= sh_left_reg - CNT_W'(1);
                end
            end
            if (cmd.finish) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            req_reg  <= s_tuser;
            need_reg <= need_in;
            fseg_reg <= s_tdata[36:21];
        end
        rd_idx_reg <= scan_addr;
        if (cmd.scan && rd_vld_reg && match) begin
            hit_reg     <= rd_data_reg;
            hit_idx_reg <= rd_idx_reg;
        end
        if (cmd.decide) begin
            hi_reg    <= hi_ent;
            sh_rd_reg <= count_reg[IDX_W-1:0] - IDX_W'(1);
            if (!found_reg) begin
                ok_reg  <= 1'b0;
                seg_reg <= '0;
            end else if (req_reg == REQ_FREE) begin
                ok_reg  <= 1'b1;
                seg_reg <= '0;
            end else if (rest_small) begin
                ok_reg  <= 1'b1;
                seg_reg <= hit_reg.start;
            end else if (full) begin
                ok_reg  <= 1'b0;
                seg_reg <= '0;
            end else begin
                ok_reg  <= 1'b1;
                seg_reg <= split_seg;
            end
        end else if (cmd.shift && sh_left_reg != '0) begin
            sh_rd_reg   <= sh_rd_reg - IDX_W'(1);
            sh_widx_reg <= sh_rd_reg + IDX_W'(1);
        end
        if (cmd.finish) begin
            m_ok_reg  <= ok_reg;
            m_seg_reg <= seg_reg;
        end
    end

    assign st.cfg_wr     = cfg_wr;
    assign st.hit        = rd_vld_reg && match;
    assign st.miss       = !rd_vld_reg && (n_reg >= count_reg);
    assign st.split      = split;
    assign st.shift_done = (sh_left_reg == '0) && !sh_wvld_reg;
    assign st.out_free   = !m_valid_reg || m_tready;
    assign st.count      = count_reg;

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {7'd0, m_seg_reg, m_ok_reg};

endmodule

@@ rtl/segment_block_allocator_core.sv @@
// Block allocator over a 16-entry address-ordered table of paragraph blocks, one request at
// a time. A request reads one table entry per cycle from the table memory in a search, then
// passes a decision state and a finish state that hands the result to the output register,
// and the next request is taken in the idle state after that. An allocation that splits a
// block also moves the entries above it up by one, one entry per cycle, and then writes the
// new entry; the longest request is a last fit split of the lowest block. A result waiting
// on the output holds the request in its final state. After reset and after every register
// write to a defined index the table is rebuilt in the init state before the next request
// is taken. The output register lets a new request start while a result waits.
module segment_block_allocator_core
    import sba_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // size_bytes[19:0], with_header[20], free_segment[36:21]
    input  logic        s_tuser,   // req_type
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // ok[0], segment[16:1]
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    cmd_t    cmd;
    status_t st;

    assign cfg_ready = 1'b1;

    sba_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .st       (st),
        .cmd      (cmd)
    );

    sba_datapath u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .st        (st),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    a_cmd_onehot: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot0({cmd.init, cmd.load, cmd.scan, cmd.decide, cmd.shift, cmd.wr_hi, cmd.finish}))
        else $error("more than one command active");

    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        st.count != '0 && st.count <= CNT_W'(MAX_BLOCKS))
        else $error("block count out of range");

    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("new transaction taken while a request is in work");

    a_insert_after_shift: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.wr_hi |-> $past(cmd.shift))
        else $error("insert write without preceding shift");

endmodule
